// ===== design/lctlpm_pkg.sv =====
// Package for the LC-trie longest prefix match block.
// Holds payload structs, field codes, table sizes and node field layout.
// No dependencies.
package lctlpm_pkg;

	localparam int NodeDepth   = 4096;
	localparam int PrefixDepth = 1024;
	localparam int MaxBranch   = 8;
	localparam int WalkLimit   = 129;

	localparam int NodeAw   = $clog2(NodeDepth);
	localparam int PrefixAw = $clog2(PrefixDepth);

	localparam logic [1:0] KIND_NODE   = 2'd0;
	localparam logic [1:0] KIND_PREFIX = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] entry_index;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [7:0]  prefix_length;
		logic [9:0]  original_index;
		logic [11:0] child_base;
		logic        node_has_prefix;
		logic [9:0]  node_prefix_slot;
		logic [3:0]  node_branch;
		logic [7:0]  node_skip;
		logic        batch_end;
	} in_item_t;

	typedef struct packed {
		logic        match_found;
		logic [9:0]  match_index;
		logic        batch_end_out;
	} out_item_t;

	// One trie node as stored
	typedef struct packed {
		logic [7:0]  skip;
		logic [3:0]  branch;
		logic [9:0]  slot;
		logic        has_prefix;
		logic [11:0] base;
	} node_t;

	// One prefix entry as stored
	typedef struct packed {
		logic [63:0] upper;
		logic [63:0] lower;
		logic [7:0]  len;
		logic [9:0]  orig;
	} prefix_t;

endpackage

// ===== design/lctlpm_node_mem.sv =====
// Trie node table: one write port, one registered read port.
// Depends on lctlpm_pkg.
module lctlpm_node_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [lctlpm_pkg::NodeAw-1:0] waddr,
	input  lctlpm_pkg::node_t          wdata,
	input  logic [lctlpm_pkg::NodeAw-1:0] raddr,
	output lctlpm_pkg::node_t          rdata
);
	import lctlpm_pkg::*;

	node_t mem [NodeDepth];

	// Write and read the table
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/lctlpm_prefix_mem.sv =====
// Prefix table: one write port, one registered read port.
// Depends on lctlpm_pkg.
module lctlpm_prefix_mem (
	input  logic                         clk,
	input  logic                         we,
	input  logic [lctlpm_pkg::PrefixAw-1:0] waddr,
	input  lctlpm_pkg::prefix_t          wdata,
	input  logic [lctlpm_pkg::PrefixAw-1:0] raddr,
	output lctlpm_pkg::prefix_t          rdata
);
	import lctlpm_pkg::*;

	prefix_t mem [PrefixDepth];

	// Write and read the table
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/lc_trie_longest_prefix_match.sv =====
// LC-trie longest prefix match, top level.
// Writes and ignored kinds complete when accepted. A lookup walks N nodes, N from
// 1 to 129 (node read, prefix read, compare and descend per level), then registers
// its result beat.
// One item in flight; the input stays blocked until the result beat is taken.
// arst_n clears control state and family_q; tables hold no reset value.
module lc_trie_longest_prefix_match (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  lctlpm_pkg::in_item_t    in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output lctlpm_pkg::out_item_t   out_data,
	input  logic                    cfg_we,
	input  logic                    cfg_wdata
);
	import lctlpm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NODE = 2'd1;
	localparam logic [1:0] ST_PFX  = 2'd2;
	localparam logic [1:0] ST_STEP = 2'd3;

	logic [1:0]  state_q;
	logic        family_q;
	logic [63:0] hi_q, lo_q;
	logic        bend_q;
	logic [7:0]  pos_q;
	logic [7:0]  steps_q;
	logic        found_q;
	logic [9:0]  best_q;
	logic [NodeAw-1:0] node_q;
	node_t       node_rd, nd_q;
	prefix_t     pfx_rd;
	logic        res_full_q;
	out_item_t   res_q;

	logic accept, node_we, pfx_we;
	logic [NodeAw-1:0] node_raddr;

	assign in_ready = (state_q == ST_IDLE) && !res_full_q;
	assign accept   = in_valid && in_ready;
	assign node_we  = accept && in_data.kind == KIND_NODE;
	assign pfx_we   = accept && in_data.kind == KIND_PREFIX
		&& in_data.entry_index < 12'(PrefixDepth);
	assign node_raddr = node_q;

	lctlpm_node_mem u_node (
		.clk(clk), .we(node_we), .waddr(in_data.entry_index[NodeAw-1:0]),
		.wdata('{skip: in_data.node_skip, branch: in_data.node_branch,
			slot: in_data.node_prefix_slot, has_prefix: in_data.node_has_prefix,
			base: in_data.child_base}),
		.raddr(node_raddr), .rdata(node_rd)
	);

	lctlpm_prefix_mem u_pfx (
		.clk(clk), .we(pfx_we), .waddr(in_data.entry_index[PrefixAw-1:0]),
		.wdata('{upper: in_data.addr_high, lower: in_data.addr_low,
			len: in_data.prefix_length, orig: in_data.original_index}),
		.raddr(node_rd.slot), .rdata(pfx_rd)
	);

	// Masked compare of the key against the fetched prefix
	logic [7:0]   key_width, plen;
	logic [127:0] mask, key, diff;
	logic         hit;
	always_comb begin
		key_width = family_q ? 8'd128 : 8'd32;
		plen = (pfx_rd.len > key_width) ? key_width : pfx_rd.len;
		mask = (plen == 8'd0) ? 128'd0 : ~(128'h0) << (8'd128 - plen);
		key  = {hi_q, lo_q};
		diff = (key ^ {pfx_rd.upper, pfx_rd.lower}) & mask;
		hit  = nd_q.has_prefix && diff == 128'd0;
	end

	// Next position, child select and stop decision
	logic [8:0]  npos, nend;
	logic [127:0] shifted;
	logic [7:0]  sel;
	logic [12:0] child;
	logic        stop;
	always_comb begin
		npos = {1'b0, pos_q} + {1'b0, nd_q.skip};
		nend = npos + {5'd0, nd_q.branch};
		shifted = key << npos[7:0];
		sel = 8'(shifted[127:120] >> (4'd8 - nd_q.branch));
		child = {1'b0, nd_q.base} + {5'd0, sel};
		stop = nd_q.branch == 4'd0 || nd_q.branch > 4'(MaxBranch)
			|| nend > {1'b0, key_width} || child >= 13'(NodeDepth)
			|| steps_q == 8'(WalkLimit - 1);
	end

	// Walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			family_q <= 1'b0;
			res_full_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				family_q <= cfg_wdata;
			end
			if (out_valid && out_ready) begin
				res_full_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_data.kind == KIND_LOOKUP) begin
						state_q <= ST_NODE;
					end
				end
				ST_NODE: state_q <= ST_PFX;
				ST_PFX:  state_q <= ST_STEP;
				ST_STEP: begin
					if (stop) begin
						state_q <= ST_IDLE;
						res_full_q <= 1'b1;
					end else begin
						state_q <= ST_NODE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			hi_q <= family_q ? in_data.addr_high : {in_data.addr_high[63:32], 32'd0};
			lo_q <= family_q ? in_data.addr_low : 64'd0;
			bend_q <= in_data.batch_end;
			node_q <= '0;
			pos_q <= '0;
			steps_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
		end
		// Node read data for node_q is registered in the table, so it is captured in ST_PFX
		if (state_q == ST_PFX) begin
			nd_q <= node_rd;
		end
		if (state_q == ST_STEP) begin
			if (hit) begin
				found_q <= 1'b1;
				best_q <= pfx_rd.orig;
			end
			pos_q <= nend[7:0];
			node_q <= child[NodeAw-1:0];
			steps_q <= steps_q + 8'd1;
			if (stop) begin
				res_q.match_found <= found_q | hit;
				res_q.match_index <= hit ? pfx_rd.orig : best_q;
				res_q.batch_end_out <= bend_q;
			end
		end
	end

	assign out_valid = res_full_q;
	assign out_data  = res_q;
endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the LC-trie longest prefix match block.
// Loads node and prefix tables, runs lookups under random stalls in both address families.
// Depends on lctlpm_pkg and lc_trie_longest_prefix_match.
`timescale 1ns / 100ps

module tb_top;
	import lctlpm_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_we;
	logic      cfg_wdata;

	lc_trie_longest_prefix_match dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the tables and the family register
	node_t     shadow_nodes [NodeDepth];
	prefix_t   shadow_prefixes [PrefixDepth];
	logic      shadow_family;

	in_item_t  pending_items[$];
	out_item_t expected_matches[$];

	// Generation-time record of written prefix addresses, used to aim lookups
	logic [127:0] aim_addrs[$];

	int errors;
	int cycle_count;
	int lookups_done;
	int hits_seen;
	int writes_done;
	int results_seen;
	int hold_left;
	bit hold_done;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Walk the shadow trie for one address and form the expected beat
	function automatic out_item_t walk_trie(in_item_t it);
		out_item_t    res;
		logic [127:0] key;
		logic [127:0] mask;
		node_t        nd;
		prefix_t      pf;
		int           key_width;
		int           node;
		int           bit_pos;
		int           len;
		int           sel;
		int           child;
		bit           found;
		logic [9:0]   best;
		key_width = shadow_family ? 128 : 32;
		key = {it.addr_high, it.addr_low};
		if (!shadow_family)
			key = {key[127:96], 96'd0};
		node = 0;
		bit_pos = 0;
		found = 1'b0;
		best = '0;
		for (int step = 0; step < WalkLimit; step++) begin
			nd = shadow_nodes[node];
			if (nd.has_prefix && nd.slot < PrefixDepth) begin
				pf = shadow_prefixes[nd.slot];
				len = (pf.len > key_width) ? key_width : pf.len;
				mask = (len == 0) ? '0 : ({128{1'b1}} << (128 - len));
				if (((key ^ {pf.upper, pf.lower}) & mask) == '0) begin
					found = 1'b1;
					best = pf.orig;
				end
			end
			if (nd.branch == 0 || nd.branch > MaxBranch)
				break;
			bit_pos += nd.skip;
			if (bit_pos + nd.branch > key_width)
				break;
			sel = 0;
			for (int b = 0; b < nd.branch; b++)
				sel = (sel << 1) | key[127 - (bit_pos + b)];
			bit_pos += nd.branch;
			child = nd.base + sel;
			if (child >= NodeDepth)
				break;
			node = child;
		end
		res.match_found = found;
		res.match_index = found ? best : 10'd0;
		res.batch_end_out = it.batch_end;
		return res;
	endfunction

	// Apply one accepted beat to the shadow state
	function automatic void absorb_item(in_item_t it);
		node_t   nd;
		prefix_t pf;
		case (it.kind)
			KIND_NODE: begin
				nd.skip = it.node_skip;
				nd.branch = it.node_branch;
				nd.slot = it.node_prefix_slot;
				nd.has_prefix = it.node_has_prefix;
				nd.base = it.child_base;
				shadow_nodes[it.entry_index] = nd;
				writes_done++;
			end
			KIND_PREFIX: begin
				if (it.entry_index < PrefixDepth) begin
					pf.upper = it.addr_high;
					pf.lower = it.addr_low;
					pf.len = it.prefix_length;
					pf.orig = it.original_index;
					shadow_prefixes[it.entry_index] = pf;
				end
				writes_done++;
			end
			KIND_LOOKUP: begin
				expected_matches.push_back(walk_trie(it));
				lookups_done++;
			end
			default: ;
		endcase
	endfunction

	function automatic bit idle_now();
		if (cycle_count >= 2000 && cycle_count < 5000)
			return 1'b0;
		return $urandom_range(99) < 22;
	endfunction

	// Driver: take beats from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready)
				absorb_item(in_data);
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && !idle_now()) begin
					in_valid <= 1'b1;
					in_data  <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check results, stall the output at random, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready   <= 1'b0;
			cycle_count <= 0;
			hold_left   <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_matches.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors++;
				end else begin
					automatic out_item_t exp_item = expected_matches.pop_front();
					if (out_data.match_found !== exp_item.match_found) begin
						$display("%0t: match_found expected %0d actual %0d", $time,
							exp_item.match_found, out_data.match_found);
						errors++;
					end
					if (out_data.match_index !== exp_item.match_index) begin
						$display("%0t: match_index expected %0d actual %0d", $time,
							exp_item.match_index, out_data.match_index);
						errors++;
					end
					if (out_data.batch_end_out !== exp_item.batch_end_out) begin
						$display("%0t: batch_end_out expected %0d actual %0d", $time,
							exp_item.batch_end_out, out_data.batch_end_out);
						errors++;
					end
					if (exp_item.match_found)
						hits_seen++;
				end
			end
			if (!hold_done && results_seen == 150) begin
				hold_done = 1'b1;
				hold_left <= 600;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !idle_now();
			end
		end
	end

	function automatic in_item_t node_beat(int idx, int base, bit has, int slot,
			int branch, int skip);
		in_item_t it;
		it = '0;
		it.kind = KIND_NODE;
		it.entry_index = 12'(idx);
		it.child_base = 12'(base);
		it.node_has_prefix = has;
		it.node_prefix_slot = 10'(slot);
		it.node_branch = 4'(branch);
		it.node_skip = 8'(skip);
		it.addr_high = {$urandom, $urandom};
		it.addr_low = {$urandom, $urandom};
		return it;
	endfunction

	function automatic in_item_t prefix_beat(int idx, logic [127:0] addr, int len,
			int orig);
		in_item_t it;
		it = '0;
		it.kind = KIND_PREFIX;
		it.entry_index = 12'(idx);
		it.addr_high = addr[127:64];
		it.addr_low = addr[63:0];
		it.prefix_length = 8'(len);
		it.original_index = 10'(orig);
		it.child_base = 12'($urandom);
		it.node_skip = 8'($urandom_range(128));
		return it;
	endfunction

	function automatic in_item_t lookup_beat(logic [127:0] addr, bit last);
		in_item_t it;
		it = '0;
		it.kind = KIND_LOOKUP;
		it.addr_high = addr[127:64];
		it.addr_low = addr[63:0];
		it.batch_end = last;
		it.original_index = 10'($urandom);
		it.node_branch = 4'($urandom_range(8));
		return it;
	endfunction

	function automatic logic [127:0] rand_addr();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Random trie content, mostly aimed lookups, a few table rewrites.
	// Reachable children stay in nodes 0..455 and 4095, prefix slots in 0..31 and 1023.
	task automatic fill_random(int count);
		logic [127:0] a;
		int           pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 18) begin
				if ($urandom_range(19) == 0)
					pending_items.push_back(node_beat($urandom_range(4095),
						($urandom_range(1) == 0) ? 4095 : $urandom_range(200),
						1'($urandom_range(1)), $urandom_range(31), $urandom_range(8),
						$urandom_range(128)));
				else
					pending_items.push_back(node_beat($urandom_range(63),
						$urandom_range(1, 56), 1'($urandom_range(1)), $urandom_range(31),
						$urandom_range(3), $urandom_range(3)));
			end else if (pick < 33) begin
				a = rand_addr();
				aim_addrs.push_back(a);
				pending_items.push_back(prefix_beat(
					($urandom_range(15) == 0) ? $urandom_range(4095) : $urandom_range(31),
					a, $urandom_range(128), $urandom_range(1023)));
			end else begin
				if (aim_addrs.size() > 0 && $urandom_range(3) != 0) begin
					a = aim_addrs[$urandom_range(aim_addrs.size() - 1)];
					a = a ^ (rand_addr() >> $urandom_range(127));
				end else begin
					a = rand_addr();
				end
				pending_items.push_back(lookup_beat(a, $urandom_range(7) == 0));
			end
		end
	endtask

	task automatic wait_idle();
		wait (pending_items.size() == 0 && !in_valid && expected_matches.size() == 0);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_family(bit fam);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= fam;
		shadow_family = fam;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		errors = 0;
		lookups_done = 0;
		hits_seen = 0;
		writes_done = 0;
		results_seen = 0;
		hold_done = 1'b0;
		shadow_family = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Clear every slot that a walk can reach so no lookup touches an unwritten entry
		for (int i = 0; i < 456; i++)
			pending_items.push_back(node_beat(i, 0, 1'b0, 0, 0, 0));
		pending_items.push_back(node_beat(4095, 0, 1'b0, 0, 0, 0));
		for (int i = 0; i < 32; i++)
			pending_items.push_back(prefix_beat(i, '0, 0, 0));
		pending_items.push_back(prefix_beat(1023, '0, 0, 0));

		// Directed: default route, long prefix, deep skip, child past the table end
		pending_items.push_back(prefix_beat(0, '0, 0, 1023));
		pending_items.push_back(prefix_beat(1, {128{1'b1}}, 128, 5));
		pending_items.push_back(prefix_beat(2, {8'hA5, 120'd0}, 8, 77));
		pending_items.push_back(prefix_beat(1023, {128{1'b1}}, 1, 9));
		pending_items.push_back(prefix_beat(4095, '0, 128, 1000));
		pending_items.push_back(node_beat(0, 1, 1'b1, 0, 8, 0));
		pending_items.push_back(node_beat(256, 0, 1'b1, 1, 0, 0));
		pending_items.push_back(node_beat(166, 4095, 1'b1, 2, 2, 128));
		pending_items.push_back(node_beat(1, 4095, 1'b1, 1023, 2, 0));
		pending_items.push_back(lookup_beat({128{1'b1}}, 1'b0));
		pending_items.push_back(lookup_beat('0, 1'b1));
		pending_items.push_back(lookup_beat({8'hA5, 120'd3}, 1'b0));
		pending_items.push_back(lookup_beat({8'h00, 2'b11, 118'd0}, 1'b1));
		pending_items.push_back(lookup_beat({8'h00, 2'b01, 118'd0}, 1'b0));
		fill_random(250);
		wait_idle();

		// Walk through both families, back and forth
		set_family(1'b1);
		pending_items.push_back(lookup_beat({128{1'b1}}, 1'b1));
		pending_items.push_back(lookup_beat({8'hA5, 120'd3}, 1'b0));
		fill_random(250);
		wait_idle();
		set_family(1'b0);
		fill_random(250);
		wait_idle();
		set_family(1'b1);
		fill_random(250);
		wait_idle();

		$display("Covered %0d table writes and %0d lookups (%0d hits) in both families.",
			writes_done, lookups_done, hits_seen);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(30_000_000);
		$display("Timed out after %0d results.", results_seen);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
design/lctlpm_pkg.sv
design/lctlpm_node_mem.sv
design/lctlpm_prefix_mem.sv
design/lc_trie_longest_prefix_match.sv
sim/tb_top.sv
